/* design/trsh_pkg.sv */
// Shared definitions for the triad sponge hash: register sizes, default rounds, field widths,
// command codes, initial B vector, cell control group and controller states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trsh_pkg;

    // Register sizes in bytes and bits
    localparam int A_BYTES  = 10;
    localparam int BC_BYTES = 11;
    localparam int A_BITS   = A_BYTES * 8;
    localparam int BC_BITS  = BC_BYTES * 8;

    // Rounds per permutation
    localparam int ROUNDS_DEF = 1024;

    // Field widths
    localparam int MSG_W    = 32;
    localparam int DIG_W    = 64;
    localparam int IDX_W    = 2;
    localparam int DIGEST_W = 256;
    localparam int HALF_W   = DIGEST_W / 2;

    // Command codes
    localparam logic CMD_ABSORB   = 1'b0;
    localparam logic CMD_FINALIZE = 1'b1;

    // Index of the final digest word
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(3);

    // Initial contents of register B, byte 0 first
    localparam logic [7:0] B_INIT [BC_BYTES] = '{
        8'hb7, 8'he1, 8'h51, 8'h62, 8'h8a, 8'he2, 8'h43, 8'hf6, 8'ha8, 8'h88, 8'h5a
    };

    // Control group broadcast to every cell
    typedef struct packed {
        logic init;    // reload the initial byte
        logic shift;   // take one bit from the neighbour
        logic absorb;  // xor the mix byte in
    } cell_ctrl_t;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PERM  = 4'b0010,
        ST_FIN   = 4'b0100,
        ST_FDONE = 4'b1000
    } state_t;

endpackage

`default_nettype wire

/* design/trsh_cell.sv */
// One byte cell of a shift register chain: shifts a bit in at the MSB end,
// hands its LSB to the next cell, absorbs a mix byte, reloads its initial byte. Depends on trsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trsh_cell #(
    parameter logic [7:0] INIT = 8'h00
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire trsh_pkg::cell_ctrl_t ctrl,
    input  wire                     shift_in,
    input  wire  [7:0]              mix,
    output logic [7:0]              value,
    output logic                    shift_out
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Select reload, shift or absorb
    always_comb begin
        byte_next = byte_reg;
        if (ctrl.init) begin
            byte_next = INIT;
        end else if (ctrl.shift) begin
            byte_next = {shift_in, byte_reg[7:1]};
        end else if (ctrl.absorb) begin
            byte_next = byte_reg ^ mix;
        end
    end

    // Hold the byte; reset to the initial value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= INIT;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign value     = byte_reg;
    assign shift_out = byte_reg[0];

endmodule

`default_nettype wire

/* design/trsh_feedback.sv */
// Feedback taps of the three nonlinear registers for one update round.
// Position p of a register sits at bit (width - p) of its flat vector. Depends on trsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trsh_feedback (
    input  wire  [trsh_pkg::A_BITS-1:0]  a_bits,
    input  wire  [trsh_pkg::BC_BITS-1:0] b_bits,
    input  wire  [trsh_pkg::BC_BITS-1:0] c_bits,
    output logic                         t1,
    output logic                         t2,
    output logic                         t3
);

    localparam int AW = trsh_pkg::A_BITS;
    localparam int BW = trsh_pkg::BC_BITS;

    // New bit for B
    assign t1 = a_bits[AW-68] ^ a_bits[AW-80] ^ (b_bits[BW-85] & c_bits[BW-85]) ^
                (a_bits[AW-73] & a_bits[AW-79]) ^ b_bits[BW-66];

    // New bit for C
    assign t2 = b_bits[BW-64] ^ b_bits[BW-88] ^ (b_bits[BW-65] & b_bits[BW-87]) ^
                c_bits[BW-84];

    // New bit for A
    assign t3 = c_bits[BW-68] ^ c_bits[BW-88] ^ (c_bits[BW-77] & c_bits[BW-87]) ^
                a_bits[AW-74];

endmodule

`default_nettype wire

/* design/triad_sponge_hash.sv */
// Top level of the triad sponge hash: three chains of byte cells, feedback taps,
// round sequencer and digest output register. Depends on trsh_pkg, trsh_cell, trsh_feedback.
// Absorb word: mixed into A when taken, then ROUNDS rounds at one per clock; s_tready low meanwhile.
// Finalize word: ROUNDS rounds, then a wait for the previous digest; four digest words out.
// One word at a time: s_tready stays low until the round loop and any digest load are done.
// Reset (aresetn low, synchronous) loads the initial state and drops any pending digest.
`timescale 1ns / 1ps
`default_nettype none

module triad_sponge_hash #(
    parameter int ROUNDS = trsh_pkg::ROUNDS_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire  [trsh_pkg::MSG_W-1:0]    s_tdata,  // message_word [31:0]
    input  wire                           s_tuser,  // command [0]
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [trsh_pkg::DIG_W-1:0]    m_tdata,  // digest_word [63:0]
    output logic [trsh_pkg::IDX_W-1:0]    m_tuser,  // word_index [1:0]
    output logic                          m_tlast
);

    localparam int AB = trsh_pkg::A_BYTES;
    localparam int CB = trsh_pkg::BC_BYTES;
    localparam int CNT_W = $clog2(ROUNDS + 1);
    localparam logic [CNT_W-1:0] LAST_RND = CNT_W'(ROUNDS - 1);

    trsh_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic [trsh_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [trsh_pkg::DIGEST_W-1:0] dig_reg, dig_next;
    logic [trsh_pkg::HALF_W-1:0]   half_reg, half_next;

    trsh_pkg::cell_ctrl_t ctrl;
    logic                 s_acc, m_acc;
    logic [7:0]           a_byte [AB];
    logic [7:0]           b_byte [CB];
    logic [7:0]           c_byte [CB];
    logic [AB-1:0]        a_out;
    logic [CB-1:0]        b_out;
    logic [CB-1:0]        c_out;
    logic [trsh_pkg::A_BITS-1:0]  a_bits;
    logic [trsh_pkg::BC_BITS-1:0] b_bits;
    logic [trsh_pkg::BC_BITS-1:0] c_bits;
    logic [trsh_pkg::HALF_W-1:0]  z_half;
    logic                 t1, t2, t3;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // Cell chains: byte 0 takes the feedback bit, each next byte takes its neighbour's LSB
    genvar gi;
    generate
        for (gi = 0; gi < AB; gi++) begin : g_a
            trsh_cell #(.INIT(8'h00)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .shift_in ((gi == 0) ? t3 : a_out[(gi == 0) ? 0 : gi - 1]),
                .mix      ((gi < 4) ? s_tdata[8*(gi%4) +: 8] : 8'h00),
                .value    (a_byte[gi]),
                .shift_out(a_out[gi])
            );
            assign a_bits[8*(AB-1-gi) +: 8] = a_byte[gi];
        end
        for (gi = 0; gi < CB; gi++) begin : g_b
            trsh_cell #(.INIT(trsh_pkg::B_INIT[gi])) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .shift_in ((gi == 0) ? t1 : b_out[(gi == 0) ? 0 : gi - 1]),
                .mix      (8'h00),
                .value    (b_byte[gi]),
                .shift_out(b_out[gi])
            );
            assign b_bits[8*(CB-1-gi) +: 8] = b_byte[gi];
        end
        for (gi = 0; gi < CB; gi++) begin : g_c
            trsh_cell #(.INIT(8'h00)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .shift_in ((gi == 0) ? t2 : c_out[(gi == 0) ? 0 : gi - 1]),
                .mix      (8'h00),
                .value    (c_byte[gi]),
                .shift_out(c_out[gi])
            );
            assign c_bits[8*(CB-1-gi) +: 8] = c_byte[gi];
        end
    endgenerate

    trsh_feedback u_fb (
        .a_bits(a_bits),
        .b_bits(b_bits),
        .c_bits(c_bits),
        .t1    (t1),
        .t2    (t2),
        .t3    (t3)
    );

    // Gather one digest half: B bytes 5..0 then A bytes 9..0, first byte highest
    always_comb begin
        for (int i = 0; i < AB; i++) begin
            z_half[8*i +: 8] = a_byte[i];
        end
        for (int i = 0; i < 6; i++) begin
            z_half[8*(AB+i) +: 8] = b_byte[i];
        end
    end

    // Sequence rounds, capture the digest, drive the cells
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        idx_next    = idx_reg;
        dig_next    = dig_reg;
        half_next   = half_reg;
        ctrl        = '0;
        s_tready    = (state_reg == trsh_pkg::ST_IDLE);

        // Drain the digest one word per handshake
        if (m_acc) begin
            dig_next = {dig_reg[trsh_pkg::DIGEST_W-trsh_pkg::DIG_W-1:0],
                        {trsh_pkg::DIG_W{1'b0}}};
            idx_next = idx_reg + 1'b1;
            if (idx_reg == trsh_pkg::LAST_IDX) begin
                pend_next = 1'b0;
            end
        end

        case (state_reg)
            trsh_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser == trsh_pkg::CMD_ABSORB) begin
                        ctrl.absorb = 1'b1;
                        state_next  = trsh_pkg::ST_PERM;
                    end else begin
                        half_next  = z_half;
                        state_next = trsh_pkg::ST_FIN;
                    end
                    cnt_next = '0;
                end
            end
            trsh_pkg::ST_PERM, trsh_pkg::ST_FIN: begin
                ctrl.shift = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == LAST_RND) begin
                    state_next = (state_reg == trsh_pkg::ST_PERM) ? trsh_pkg::ST_IDLE
                                                                  : trsh_pkg::ST_FDONE;
                end
            end
            trsh_pkg::ST_FDONE: begin
                // Wait for the previous digest to leave, then load and reinitialise
                if (!pend_reg) begin
                    dig_next   = {half_reg, z_half};
                    pend_next  = 1'b1;
                    idx_next   = '0;
                    ctrl.init  = 1'b1;
                    state_next = trsh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = trsh_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= trsh_pkg::ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        dig_reg  <= dig_next;
        half_reg <= half_next;
    end

    assign m_tvalid = pend_reg;
    assign m_tdata  = dig_reg[trsh_pkg::DIGEST_W-1 -: trsh_pkg::DIG_W];
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == trsh_pkg::LAST_IDX);

endmodule

`default_nettype wire

/* design/trsh_checker.sv */
// Port-level checks for the triad sponge hash, bound to the top level.
// Depends on trsh_pkg and triad_sponge_hash.
`timescale 1ns / 1ps
`default_nettype none

module trsh_checker (
    input wire                         aclk,
    input wire                         aresetn,
    input wire                         s_tvalid,
    input wire                         s_tready,
    input wire [trsh_pkg::MSG_W-1:0]   s_tdata,
    input wire                         s_tuser,
    input wire                         m_tvalid,
    input wire                         m_tready,
    input wire [trsh_pkg::DIG_W-1:0]   m_tdata,
    input wire [trsh_pkg::IDX_W-1:0]   m_tuser,
    input wire                         m_tlast
);

    // A stalled digest word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("digest word changed while stalled");

    // tlast marks exactly the final quarter
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == trsh_pkg::LAST_IDX)))
        else $error("tlast does not match word index");

    // Digest words follow one another in order
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tuser == $past(m_tuser) + 1'b1))
        else $error("digest words out of order");

    // An accepted word is known, and the block is busy in the round loop after it
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !$isunknown({s_tuser, s_tdata}) ##1 !s_tready)
        else $error("unknown word taken or input taken during permutation");

    // Reset drops any pending digest
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("digest pending after reset");

endmodule

bind triad_sponge_hash trsh_checker u_trsh_checker (.*);

`default_nettype wire
